@@ hdl/spi_pkg.sv @@
// Shared types and constants for the segment pair intersection block.
package spi_pkg;

	localparam int COORD_BITS = 32;
	localparam int EPS_BITS = 16;
	localparam int KIND_BITS = 3;

	localparam logic [KIND_BITS-1:0] KIND_NONE    = 3'd0;
	localparam logic [KIND_BITS-1:0] KIND_B_START = 3'd1;
	localparam logic [KIND_BITS-1:0] KIND_B_END   = 3'd2;
	localparam logic [KIND_BITS-1:0] KIND_A_START = 3'd3;
	localparam logic [KIND_BITS-1:0] KIND_A_END   = 3'd4;
	localparam logic [KIND_BITS-1:0] KIND_CROSS   = 3'd5;

	localparam logic [COORD_BITS-1:0] COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};

	typedef struct packed {
		logic signed [COORD_BITS-1:0] a_start_x;
		logic signed [COORD_BITS-1:0] a_start_y;
		logic signed [COORD_BITS-1:0] a_end_x;
		logic signed [COORD_BITS-1:0] a_end_y;
		logic signed [COORD_BITS-1:0] b_start_x;
		logic signed [COORD_BITS-1:0] b_start_y;
		logic signed [COORD_BITS-1:0] b_end_x;
		logic signed [COORD_BITS-1:0] b_end_y;
	} seg_pair_t;

	typedef struct packed {
		logic                         hit;
		logic [KIND_BITS-1:0]         hit_kind;
		logic signed [COORD_BITS-1:0] cross_x;
		logic signed [COORD_BITS-1:0] cross_y;
	} isect_t;

endpackage

@@ hdl/segment_pair_intersection_top.sv @@
// Segment pair intersection: deep pipeline with endpoint tests, straddle test and divider.
//
// Usage: each request on the input channel carries two segments A and B with
// signed Q16.16 endpoints. Each request yields exactly one result on the
// output channel: hit, hit_kind and the meeting point, or the largest
// coordinate in both fields on a miss.
// The input request is taken at a clock edge where in_valid is high and
// in_stall is low; the result is taken where out_valid is high and out_stall
// is low. A new request can be taken in every cycle in which in_stall is low.
// The pipeline has six arithmetic stages, one decision stage, one stage
// per quotient bit of the crossing divider (32), and the output register.
// Throughput is one request per cycle while out_stall does not hold the pipeline; the divider is fully unrolled.
// While a result waits with out_stall high, the whole pipeline holds and
// in_stall is raised, so nothing is lost or repeated.
// The epsilon register is written through cfg_wr_en and cfg_wr_data; its
// square is kept in a register, and it must only change while the pipeline
// is empty. Reset clears all valid bits and sets epsilon to one.
module segment_pair_intersection_top (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wr_en,
	input  logic [15:0]                       cfg_wr_data,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  spi_pkg::seg_pair_t                in_data,
	output logic                              out_valid,
	input  logic                              out_stall,
	output spi_pkg::isect_t                   out_data
);
	import spi_pkg::*;

	localparam int C   = COORD_BITS;
	localparam int D   = C + 1;
	localparam int P   = 2 * D;
	localparam int W   = P + 1;
	localparam int E2  = 2 * EPS_BITS;
	localparam int SQ  = C + EPS_BITS + 1;
	localparam int H   = (SQ + 1) / 2;
	localparam int HH  = SQ - H;
	localparam int LW  = 2 * SQ;
	localparam int NW  = C + P + 1;
	localparam int DVW = P + 2;
	localparam int RW  = DVW + 1;

	typedef struct packed {
		seg_pair_t          pts;
		logic signed [D-1:0] uax, uay, ubx, uby;
		logic signed [D-1:0] bssx, bssy, besx, besy;
		logic signed [D-1:0] bsex, bsey, beex, beey;
		logic signed [D-1:0] sbsx, sbsy, ebsx, ebsy;
	} st1_t;

	typedef struct packed {
		seg_pair_t           pts;
		logic signed [D-1:0] uax, uay;
		logic signed [P-1:0] la_x, la_y, lb_x, lb_y;
		logic signed [P-1:0] qbss_x, qbss_y, qbes_x, qbes_y;
		logic signed [P-1:0] qbse_x, qbse_y, qbee_x, qbee_y;
		logic signed [P-1:0] dt1_x, dt1_y, dt2_x, dt2_y;
		logic signed [P-1:0] dt3_x, dt3_y, dt4_x, dt4_y;
		logic signed [P-1:0] c1_a, c1_b, c2_a, c2_b;
		logic signed [P-1:0] c3_a, c3_b, c4_a, c4_b;
	} st2_t;

	typedef struct packed {
		seg_pair_t           pts;
		logic signed [D-1:0] uax, uay;
		logic signed [W-1:0] la, lb;
		logic signed [W-1:0] dt1, dt2, dt3, dt4;
		logic signed [W-1:0] dbss, dbes, dbse, dbee;
		logic signed [W-1:0] cc1, cc2, cc3, cc4;
	} st3_t;

	typedef struct packed {
		seg_pair_t            pts;
		logic [3:0]           perp;
		logic [3:0]           near;
		logic [3:0]           tiny;
		logic [3:0][SQ-1:0]   cm;
		logic [P-1:0]         la, lb;
		logic [P-1:0]         cc3m, cc4m;
		logic                 cross_ok;
		logic                 negx, negy;
		logic [C-1:0]         adx, ady;
	} st4_t;

	typedef struct packed {
		seg_pair_t               pts;
		logic [3:0]              perp;
		logic [3:0]              near;
		logic [3:0]              tiny;
		logic [3:0][2*HH-1:0]    hh;
		logic [3:0][HH+H-1:0]    hl;
		logic [3:0][2*H-1:0]     ll;
		logic [1:0][E2+D-1:0]    plo, phi;
		logic [C+D-1:0]          nxlo, nxhi, nylo, nyhi;
		logic [P:0]              den;
		logic                    cross_ok;
		logic                    negx, negy;
	} st5_t;

	typedef struct packed {
		seg_pair_t          pts;
		logic [3:0]         perp;
		logic [3:0]         near;
		logic [3:0]         tiny;
		logic [3:0][LW-1:0] c2;
		logic [1:0][LW-1:0] lim;
		logic [NW-1:0]      nx, ny;
		logic [DVW-1:0]     dv;
		logic               cross_ok;
		logic               negx, negy;
	} st6_t;

	typedef struct packed {
		logic [KIND_BITS-1:0] kind;
		logic [C-1:0]         rx, ry;
		logic [C-1:0]         ex, ey;
		logic                 negx, negy;
		logic [DVW-1:0]       dv;
		logic [RW-1:0]        remx, remy;
		logic [C-1:0]         nlx, nly;
		logic [C-1:0]         qx, qy;
	} dst_t;

	function automatic logic [P-1:0] mag_of(input logic signed [W-1:0] v);
		logic signed [W-1:0] n;
		n = -v;
		return v[W-1] ? n[P-1:0] : v[P-1:0];
	endfunction

	// Returns {perpendicular case, near by endpoint distance}.
	function automatic logic [1:0] mode_of(input logic signed [W-1:0] len,
			input logic signed [W-1:0] dt, input logic signed [W-1:0] ds,
			input logic signed [W-1:0] de, input logic [P-1:0] e2);
		logic st;
		logic past;
		st = (len == '0) || dt[W-1];
		past = dt > len;
		if (st) begin
			return {1'b0, ds[P-1:0] < e2};
		end
		if (past) begin
			return {1'b0, de[P-1:0] < e2};
		end
		return 2'b10;
	endfunction

	logic [E2-1:0] eps2_q;
	logic          en;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	st1_t st_s1;
	st2_t st_s2;
	st3_t st_s3;
	st4_t st_s4;
	st5_t st_s5;
	st6_t st_s6;
	st1_t n1;
	st2_t n2;
	st3_t n3;
	st4_t n4;
	st5_t n5;
	st6_t n6;
	dst_t n7;

	logic          div_v_s [0:C];
	dst_t          div_s   [0:C];
	logic          out_valid_q;
	isect_t        out_q;
	isect_t        out_n;

	assign en = !(out_valid_q && out_stall);
	assign in_stall = !en;
	assign out_valid = out_valid_q;
	assign out_data = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eps2_q <= E2'(1);
		end else if (cfg_wr_en) begin
			eps2_q <= E2'(cfg_wr_data) * E2'(cfg_wr_data);
		end
	end

	always_comb begin
		n1.pts  = in_data;
		n1.uax  = D'(in_data.a_end_x) - D'(in_data.a_start_x);
		n1.uay  = D'(in_data.a_end_y) - D'(in_data.a_start_y);
		n1.ubx  = D'(in_data.b_end_x) - D'(in_data.b_start_x);
		n1.uby  = D'(in_data.b_end_y) - D'(in_data.b_start_y);
		n1.bssx = D'(in_data.b_start_x) - D'(in_data.a_start_x);
		n1.bssy = D'(in_data.b_start_y) - D'(in_data.a_start_y);
		n1.besx = D'(in_data.b_end_x) - D'(in_data.a_start_x);
		n1.besy = D'(in_data.b_end_y) - D'(in_data.a_start_y);
		n1.bsex = D'(in_data.b_start_x) - D'(in_data.a_end_x);
		n1.bsey = D'(in_data.b_start_y) - D'(in_data.a_end_y);
		n1.beex = D'(in_data.b_end_x) - D'(in_data.a_end_x);
		n1.beey = D'(in_data.b_end_y) - D'(in_data.a_end_y);
		n1.sbsx = D'(in_data.a_start_x) - D'(in_data.b_start_x);
		n1.sbsy = D'(in_data.a_start_y) - D'(in_data.b_start_y);
		n1.ebsx = D'(in_data.a_end_x) - D'(in_data.b_start_x);
		n1.ebsy = D'(in_data.a_end_y) - D'(in_data.b_start_y);
	end

	always_comb begin
		n2.pts    = st_s1.pts;
		n2.uax    = st_s1.uax;
		n2.uay    = st_s1.uay;
		n2.la_x   = P'(st_s1.uax) * P'(st_s1.uax);
		n2.la_y   = P'(st_s1.uay) * P'(st_s1.uay);
		n2.lb_x   = P'(st_s1.ubx) * P'(st_s1.ubx);
		n2.lb_y   = P'(st_s1.uby) * P'(st_s1.uby);
		n2.qbss_x = P'(st_s1.bssx) * P'(st_s1.bssx);
		n2.qbss_y = P'(st_s1.bssy) * P'(st_s1.bssy);
		n2.qbes_x = P'(st_s1.besx) * P'(st_s1.besx);
		n2.qbes_y = P'(st_s1.besy) * P'(st_s1.besy);
		n2.qbse_x = P'(st_s1.bsex) * P'(st_s1.bsex);
		n2.qbse_y = P'(st_s1.bsey) * P'(st_s1.bsey);
		n2.qbee_x = P'(st_s1.beex) * P'(st_s1.beex);
		n2.qbee_y = P'(st_s1.beey) * P'(st_s1.beey);
		n2.dt1_x  = P'(st_s1.bssx) * P'(st_s1.uax);
		n2.dt1_y  = P'(st_s1.bssy) * P'(st_s1.uay);
		n2.dt2_x  = P'(st_s1.besx) * P'(st_s1.uax);
		n2.dt2_y  = P'(st_s1.besy) * P'(st_s1.uay);
		n2.dt3_x  = P'(st_s1.sbsx) * P'(st_s1.ubx);
		n2.dt3_y  = P'(st_s1.sbsy) * P'(st_s1.uby);
		n2.dt4_x  = P'(st_s1.ebsx) * P'(st_s1.ubx);
		n2.dt4_y  = P'(st_s1.ebsy) * P'(st_s1.uby);
		n2.c1_a   = P'(st_s1.uax) * P'(st_s1.bssy);
		n2.c1_b   = P'(st_s1.uay) * P'(st_s1.bssx);
		n2.c2_a   = P'(st_s1.uax) * P'(st_s1.besy);
		n2.c2_b   = P'(st_s1.uay) * P'(st_s1.besx);
		n2.c3_a   = P'(st_s1.ubx) * P'(st_s1.sbsy);
		n2.c3_b   = P'(st_s1.uby) * P'(st_s1.sbsx);
		n2.c4_a   = P'(st_s1.ubx) * P'(st_s1.ebsy);
		n2.c4_b   = P'(st_s1.uby) * P'(st_s1.ebsx);
	end

	always_comb begin
		n3.pts  = st_s2.pts;
		n3.uax  = st_s2.uax;
		n3.uay  = st_s2.uay;
		n3.la   = W'(st_s2.la_x) + W'(st_s2.la_y);
		n3.lb   = W'(st_s2.lb_x) + W'(st_s2.lb_y);
		n3.dt1  = W'(st_s2.dt1_x) + W'(st_s2.dt1_y);
		n3.dt2  = W'(st_s2.dt2_x) + W'(st_s2.dt2_y);
		n3.dt3  = W'(st_s2.dt3_x) + W'(st_s2.dt3_y);
		n3.dt4  = W'(st_s2.dt4_x) + W'(st_s2.dt4_y);
		n3.dbss = W'(st_s2.qbss_x) + W'(st_s2.qbss_y);
		n3.dbes = W'(st_s2.qbes_x) + W'(st_s2.qbes_y);
		n3.dbse = W'(st_s2.qbse_x) + W'(st_s2.qbse_y);
		n3.dbee = W'(st_s2.qbee_x) + W'(st_s2.qbee_y);
		n3.cc1  = W'(st_s2.c1_a) - W'(st_s2.c1_b);
		n3.cc2  = W'(st_s2.c2_a) - W'(st_s2.c2_b);
		n3.cc3  = W'(st_s2.c3_a) - W'(st_s2.c3_b);
		n3.cc4  = W'(st_s2.c4_a) - W'(st_s2.c4_b);
	end

	always_comb begin
		logic [P-1:0]      e2;
		logic [3:0][P-1:0] m;
		logic [3:0][1:0]   md;
		logic              deg_ok;
		logic              str_a;
		logic              str_b;
		logic [D-1:0]      nax;
		logic [D-1:0]      nay;
		e2 = P'(eps2_q);
		m[0] = mag_of(st_s3.cc1);
		m[1] = mag_of(st_s3.cc2);
		m[2] = mag_of(st_s3.cc3);
		m[3] = mag_of(st_s3.cc4);
		md[0] = mode_of(st_s3.la, st_s3.dt1, st_s3.dbss, st_s3.dbse, e2);
		md[1] = mode_of(st_s3.la, st_s3.dt2, st_s3.dbes, st_s3.dbee, e2);
		md[2] = mode_of(st_s3.lb, st_s3.dt3, st_s3.dbss, st_s3.dbes, e2);
		md[3] = mode_of(st_s3.lb, st_s3.dt4, st_s3.dbse, st_s3.dbee, e2);
		deg_ok = (st_s3.la[P-1:0] >= e2) && (st_s3.lb[P-1:0] >= e2);
		str_a = (st_s3.cc1 != '0) && (st_s3.cc2 != '0) && (st_s3.cc1[W-1] != st_s3.cc2[W-1]);
		str_b = (st_s3.cc3 != '0) && (st_s3.cc4 != '0) && (st_s3.cc3[W-1] != st_s3.cc4[W-1]);
		nax = -st_s3.uax;
		nay = -st_s3.uay;
		for (int k = 0; k < 4; k++) begin
			n4.perp[k]  = md[k][1];
			n4.near[k]  = md[k][0];
			n4.tiny[k]  = (m[k][P-1:SQ] == '0);
			n4.cm[k]    = m[k][SQ-1:0];
		end
		n4.pts      = st_s3.pts;
		n4.la       = st_s3.la[P-1:0];
		n4.lb       = st_s3.lb[P-1:0];
		n4.cc3m     = m[2];
		n4.cc4m     = m[3];
		n4.cross_ok = deg_ok && str_a && str_b;
		n4.negx     = !st_s3.uax[D-1] && (st_s3.uax != '0);
		n4.negy     = !st_s3.uay[D-1] && (st_s3.uay != '0);
		n4.adx      = st_s3.uax[D-1] ? nax[C-1:0] : st_s3.uax[C-1:0];
		n4.ady      = st_s3.uay[D-1] ? nay[C-1:0] : st_s3.uay[C-1:0];
	end

	always_comb begin
		logic [HH-1:0] hi;
		logic [H-1:0]  lo;
		n5.pts      = st_s4.pts;
		n5.perp     = st_s4.perp;
		n5.near     = st_s4.near;
		n5.tiny     = st_s4.tiny;
		n5.cross_ok = st_s4.cross_ok;
		n5.negx     = st_s4.negx;
		n5.negy     = st_s4.negy;
		for (int k = 0; k < 4; k++) begin
			hi = st_s4.cm[k][SQ-1:H];
			lo = st_s4.cm[k][H-1:0];
			n5.hh[k] = (2*HH)'(hi) * (2*HH)'(hi);
			n5.hl[k] = (HH+H)'(hi) * (HH+H)'(lo);
			n5.ll[k] = (2*H)'(lo) * (2*H)'(lo);
		end
		n5.plo[0] = (E2+D)'(eps2_q) * (E2+D)'(st_s4.la[D-1:0]);
		n5.phi[0] = (E2+D)'(eps2_q) * (E2+D)'(st_s4.la[P-1:D]);
		n5.plo[1] = (E2+D)'(eps2_q) * (E2+D)'(st_s4.lb[D-1:0]);
		n5.phi[1] = (E2+D)'(eps2_q) * (E2+D)'(st_s4.lb[P-1:D]);
		n5.nxlo   = (C+D)'(st_s4.adx) * (C+D)'(st_s4.cc4m[D-1:0]);
		n5.nxhi   = (C+D)'(st_s4.adx) * (C+D)'(st_s4.cc4m[P-1:D]);
		n5.nylo   = (C+D)'(st_s4.ady) * (C+D)'(st_s4.cc4m[D-1:0]);
		n5.nyhi   = (C+D)'(st_s4.ady) * (C+D)'(st_s4.cc4m[P-1:D]);
		n5.den    = (P+1)'(st_s4.cc3m) + (P+1)'(st_s4.cc4m);
	end

	always_comb begin
		n6.pts      = st_s5.pts;
		n6.perp     = st_s5.perp;
		n6.near     = st_s5.near;
		n6.tiny     = st_s5.tiny;
		n6.cross_ok = st_s5.cross_ok;
		n6.negx     = st_s5.negx;
		n6.negy     = st_s5.negy;
		for (int k = 0; k < 4; k++) begin
			n6.c2[k] = (LW'(st_s5.hh[k]) << (2*H)) + (LW'(st_s5.hl[k]) << (H+1))
				+ LW'(st_s5.ll[k]);
		end
		for (int j = 0; j < 2; j++) begin
			n6.lim[j] = (LW'(st_s5.phi[j]) << D) + LW'(st_s5.plo[j]);
		end
		n6.nx = (NW'(st_s5.nxhi) << (D+1)) + (NW'(st_s5.nxlo) << 1) + NW'(st_s5.den);
		n6.ny = (NW'(st_s5.nyhi) << (D+1)) + (NW'(st_s5.nylo) << 1) + NW'(st_s5.den);
		n6.dv = {st_s5.den, 1'b0};
	end

	always_comb begin
		logic [3:0] on;
		for (int k = 0; k < 4; k++) begin
			on[k] = st_s6.near[k] || (st_s6.perp[k] && st_s6.tiny[k]
				&& (st_s6.c2[k] < st_s6.lim[k/2]));
		end
		n7.kind = KIND_NONE;
		n7.rx   = COORD_MAX;
		n7.ry   = COORD_MAX;
		if (on[0]) begin
			n7.kind = KIND_B_START;
			n7.rx   = st_s6.pts.b_start_x;
			n7.ry   = st_s6.pts.b_start_y;
		end else if (on[1]) begin
			n7.kind = KIND_B_END;
			n7.rx   = st_s6.pts.b_end_x;
			n7.ry   = st_s6.pts.b_end_y;
		end else if (on[2]) begin
			n7.kind = KIND_A_START;
			n7.rx   = st_s6.pts.a_start_x;
			n7.ry   = st_s6.pts.a_start_y;
		end else if (on[3]) begin
			n7.kind = KIND_A_END;
			n7.rx   = st_s6.pts.a_end_x;
			n7.ry   = st_s6.pts.a_end_y;
		end else if (st_s6.cross_ok) begin
			n7.kind = KIND_CROSS;
		end
		n7.ex   = st_s6.pts.a_end_x;
		n7.ey   = st_s6.pts.a_end_y;
		n7.negx = st_s6.negx;
		n7.negy = st_s6.negy;
		n7.dv   = st_s6.dv;
		n7.remx = RW'(st_s6.nx[NW-1:C]);
		n7.remy = RW'(st_s6.ny[NW-1:C]);
		n7.nlx  = st_s6.nx[C-1:0];
		n7.nly  = st_s6.ny[C-1:0];
		n7.qx   = '0;
		n7.qy   = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			div_v_s[0] <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			div_v_s[0] <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			st_s1 <= n1;
			st_s2 <= n2;
			st_s3 <= n3;
			st_s4 <= n4;
			st_s5 <= n5;
			st_s6 <= n6;
			div_s[0] <= n7;
		end
	end

	// One quotient bit per stage, most significant first.
	for (genvar k = 0; k < C; k++) begin : g_div
		dst_t nd;

		always_comb begin
			logic [RW-1:0] tx;
			logic [RW-1:0] ty;
			nd = div_s[k];
			tx = {div_s[k].remx[RW-2:0], div_s[k].nlx[C-1-k]};
			ty = {div_s[k].remy[RW-2:0], div_s[k].nly[C-1-k]};
			nd.remx = tx;
			nd.remy = ty;
			if (tx >= RW'(div_s[k].dv)) begin
				nd.remx = tx - RW'(div_s[k].dv);
				nd.qx[C-1-k] = 1'b1;
			end
			if (ty >= RW'(div_s[k].dv)) begin
				nd.remy = ty - RW'(div_s[k].dv);
				nd.qy[C-1-k] = 1'b1;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				div_v_s[k+1] <= 1'b0;
			end else if (en) begin
				div_v_s[k+1] <= div_v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				div_s[k+1] <= nd;
			end
		end
	end

	always_comb begin
		out_n.hit      = (div_s[C].kind != KIND_NONE);
		out_n.hit_kind = div_s[C].kind;
		out_n.cross_x  = div_s[C].rx;
		out_n.cross_y  = div_s[C].ry;
		if (div_s[C].kind == KIND_CROSS) begin
			out_n.cross_x = div_s[C].negx ? div_s[C].ex - div_s[C].qx
				: div_s[C].ex + div_s[C].qx;
			out_n.cross_y = div_s[C].negy ? div_s[C].ey - div_s[C].qy
				: div_s[C].ey + div_s[C].qy;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= div_v_s[C];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_q <= out_n;
		end
	end

endmodule

@@ hdl/spi_checker.sv @@
// Port-level checker for the segment pair intersection block, with its bind.
module spi_port_checker (
	input logic            clk,
	input logic            arst_n,
	input logic            in_stall,
	input logic            out_valid,
	input logic            out_stall,
	input spi_pkg::isect_t out_data
);
	import spi_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("Stalled result changed.");

	a_hit_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.hit == (out_data.hit_kind != KIND_NONE))
		else $error("Hit flag disagrees with hit kind.");

	a_miss_coord: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.hit |->
		out_data.cross_x == COORD_MAX && out_data.cross_y == COORD_MAX)
		else $error("Miss does not report the largest coordinate.");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("Input stalled while the output is free.");

endmodule

bind segment_pair_intersection_top spi_port_checker u_spi_port_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_data  (out_data)
);

@@ sim/spi_checker.sv @@
// Checker for the segment pair intersection block: predicts each result and compares.
`timescale 1ns / 1ps

module spi_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wr_en,
	input  logic [15:0]        cfg_wr_data,
	input  logic               in_valid,
	input  logic               in_stall,
	input  spi_pkg::seg_pair_t in_data,
	input  logic               out_valid,
	input  logic               out_stall,
	input  spi_pkg::isect_t    out_data,
	output int                 errors,
	output int                 pending
);
	import spi_pkg::*;

	typedef logic signed [199:0] wide_t;

	logic [EPS_BITS-1:0] eps_model;
	isect_t              expected_q[$];

	function automatic wide_t ext(logic [COORD_BITS-1:0] v);
		return wide_t'(signed'(v));
	endfunction

	function automatic wide_t mag(wide_t v);
		return (v < 0) ? -v : v;
	endfunction

	function automatic wide_t cross2(wide_t ux, wide_t uy, wide_t vx, wide_t vy);
		return ux * vy - uy * vx;
	endfunction

	function automatic bit near_segment(wide_t px, wide_t py, wide_t sx, wide_t sy,
			wide_t ex, wide_t ey, wide_t eps2);
		wide_t dx, dy, ux, uy, len2, dt, c;
		dx = px - sx;
		dy = py - sy;
		ux = ex - sx;
		uy = ey - sy;
		len2 = ux * ux + uy * uy;
		dt = dx * ux + dy * uy;
		if (len2 == 0 || dt < 0)
			return (dx * dx + dy * dy) < eps2;
		if (dt > len2)
			return ((px - ex) * (px - ex) + (py - ey) * (py - ey)) < eps2;
		c = cross2(dx, dy, ux, uy);
		return (c * c) < (eps2 * len2);
	endfunction

	function automatic logic [COORD_BITS-1:0] crossing_coord(wide_t s, wide_t e,
			wide_t cc4, wide_t den);
		wide_t n, q, pos;
		n = (s - e) * cc4;
		q = (2 * mag(n) + mag(den)) / (2 * mag(den));
		pos = ((n < 0) != (den < 0)) ? e - q : e + q;
		return pos[COORD_BITS-1:0];
	endfunction

	function automatic bit opposite(wide_t a, wide_t b);
		return (a < 0 && b > 0) || (a > 0 && b < 0);
	endfunction

	function automatic isect_t predict_isect(seg_pair_t p, logic [EPS_BITS-1:0] eps);
		wide_t sx, sy, ex, ey, bsx, bsy, bex, bey, eps2, la, lb, cc1, cc2, cc3, cc4;
		isect_t r;
		sx = ext(p.a_start_x);
		sy = ext(p.a_start_y);
		ex = ext(p.a_end_x);
		ey = ext(p.a_end_y);
		bsx = ext(p.b_start_x);
		bsy = ext(p.b_start_y);
		bex = ext(p.b_end_x);
		bey = ext(p.b_end_y);
		eps2 = wide_t'(eps) * wide_t'(eps);
		r.hit = 1'b1;
		r.cross_x = COORD_MAX;
		r.cross_y = COORD_MAX;
		if (near_segment(bsx, bsy, sx, sy, ex, ey, eps2)) begin
			r.hit_kind = KIND_B_START;
			r.cross_x = p.b_start_x;
			r.cross_y = p.b_start_y;
		end else if (near_segment(bex, bey, sx, sy, ex, ey, eps2)) begin
			r.hit_kind = KIND_B_END;
			r.cross_x = p.b_end_x;
			r.cross_y = p.b_end_y;
		end else if (near_segment(sx, sy, bsx, bsy, bex, bey, eps2)) begin
			r.hit_kind = KIND_A_START;
			r.cross_x = p.a_start_x;
			r.cross_y = p.a_start_y;
		end else if (near_segment(ex, ey, bsx, bsy, bex, bey, eps2)) begin
			r.hit_kind = KIND_A_END;
			r.cross_x = p.a_end_x;
			r.cross_y = p.a_end_y;
		end else begin
			r.hit = 1'b0;
			r.hit_kind = KIND_NONE;
			la = (ex - sx) * (ex - sx) + (ey - sy) * (ey - sy);
			lb = (bex - bsx) * (bex - bsx) + (bey - bsy) * (bey - bsy);
			if (la >= eps2 && lb >= eps2) begin
				cc1 = cross2(ex - sx, ey - sy, bsx - sx, bsy - sy);
				cc2 = cross2(ex - sx, ey - sy, bex - sx, bey - sy);
				cc3 = cross2(bex - bsx, bey - bsy, sx - bsx, sy - bsy);
				cc4 = cross2(bex - bsx, bey - bsy, ex - bsx, ey - bsy);
				if (opposite(cc1, cc2) && opposite(cc3, cc4)) begin
					r.hit = 1'b1;
					r.hit_kind = KIND_CROSS;
					r.cross_x = crossing_coord(sx, ex, cc4, cc4 - cc3);
					r.cross_y = crossing_coord(sy, ey, cc4, cc4 - cc3);
				end
			end
		end
		return r;
	endfunction

	task automatic report(string field, logic [COORD_BITS-1:0] got,
			logic [COORD_BITS-1:0] want);
		if (errors < 40)
			$display("mismatch at %0t: %s got %h expected %h", $realtime, field, got, want);
		errors++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eps_model <= 16'd1;
			errors = 0;
			expected_q.delete();
			pending = 0;
		end else begin
			isect_t want;
			if (cfg_wr_en)
				eps_model <= cfg_wr_data;
			if (in_valid && !in_stall)
				expected_q.push_back(predict_isect(in_data, eps_model));
			if (out_valid && !out_stall) begin
				if (expected_q.size() == 0) begin
					report("unexpected result", 32'(out_data.hit_kind), '0);
				end else begin
					want = expected_q.pop_front();
					if (out_data.hit !== want.hit)
						report("hit", 32'(out_data.hit), 32'(want.hit));
					if (out_data.hit_kind !== want.hit_kind)
						report("hit_kind", 32'(out_data.hit_kind), 32'(want.hit_kind));
					if (out_data.cross_x !== want.cross_x)
						report("cross_x", out_data.cross_x, want.cross_x);
					if (out_data.cross_y !== want.cross_y)
						report("cross_y", out_data.cross_y, want.cross_y);
				end
			end
			pending = expected_q.size();
		end
	end

endmodule

@@ sim/tb.sv @@
// Testbench top for the segment pair intersection block: stimulus, stalls and verdict.
`timescale 1ns / 1ps

module tb;
	import spi_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        cfg_wr_en;
	logic [15:0] cfg_wr_data;
	logic        in_valid;
	logic        in_stall;
	seg_pair_t   in_data;
	logic        out_valid;
	logic        out_stall;
	isect_t      out_data;
	int          errors;
	int          pending;
	bit          long_hold;
	int          stall_pct;

	segment_pair_intersection_top uut (
		.clk(clk), .arst_n(arst_n), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
	);

	spi_checker u_checker (
		.clk(clk), .arst_n(arst_n), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.errors(errors), .pending(pending)
	);

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	initial begin
		#3000000;
		$display("RESULT: ERROR");
		$finish;
	end

	// The receiver stalls at a rate that drifts, and holds off for a long stretch on request.
	initial begin
		out_stall = 1'b0;
		stall_pct = 0;
		forever begin
			@(posedge clk);
			if (long_hold) begin
				out_stall <= 1'b1;
				repeat (180) @(posedge clk);
				long_hold = 1'b0;
				out_stall <= 1'b0;
			end else begin
				if ($urandom_range(0, 149) == 0)
					case ($urandom_range(0, 3))
						0: stall_pct = 0;
						1: stall_pct = 20;
						2: stall_pct = 50;
						default: stall_pct = 85;
					endcase
				out_stall <= ($urandom_range(0, 99) < stall_pct);
			end
		end
	end

	int burst_left;

	task automatic send(seg_pair_t p);
		int gap;
		in_valid <= 1'b1;
		in_data <= p;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(0, 30);
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	task automatic write_epsilon(logic [15:0] v);
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (45) @(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	function automatic seg_pair_t make_pair(int ax0, int ay0, int ax1, int ay1,
			int bx0, int by0, int bx1, int by1);
		seg_pair_t p;
		p.a_start_x = ax0;
		p.a_start_y = ay0;
		p.a_end_x = ax1;
		p.a_end_y = ay1;
		p.b_start_x = bx0;
		p.b_start_y = by0;
		p.b_end_x = bx1;
		p.b_end_y = by1;
		return p;
	endfunction

	function automatic logic [31:0] extreme_value();
		case ($urandom_range(0, 5))
			0: return 32'h7fffffff;
			1: return 32'h80000000;
			2: return 32'h0;
			3: return 32'hffffffff;
			4: return 32'h1;
			default: return $urandom();
		endcase
	endfunction

	function automatic logic [31:0] coord(int span_bits);
		longint v;
		v = longint'($urandom()) & ((64'd1 << span_bits) - 1);
		return 32'(v - (64'd1 << (span_bits - 1)));
	endfunction

	function automatic seg_pair_t random_pair();
		seg_pair_t p;
		logic [31:0] c[8];
		longint mx, my;
		int span, jit;
		span = $urandom_range(0, 3) == 0 ? 32 : $urandom_range(4, 24);
		foreach (c[i]) c[i] = coord(span);
		jit = $urandom_range(0, 400);
		case ($urandom_range(0, 6))
			0, 1: ;
			2: begin
				// One endpoint placed on or near the midpoint of one of the two segments.
				case ($urandom_range(0, 3))
					0, 1: begin
						mx = (longint'(signed'(c[0])) + longint'(signed'(c[2]))) >>> 1;
						my = (longint'(signed'(c[1])) + longint'(signed'(c[3]))) >>> 1;
					end
					default: begin
						mx = (longint'(signed'(c[4])) + longint'(signed'(c[6]))) >>> 1;
						my = (longint'(signed'(c[5])) + longint'(signed'(c[7]))) >>> 1;
					end
				endcase
				mx += $urandom_range(0, 2 * jit) - jit;
				my += $urandom_range(0, 2 * jit) - jit;
				case ($urandom_range(0, 3))
					0: begin c[4] = 32'(mx); c[5] = 32'(my); end
					1: begin c[6] = 32'(mx); c[7] = 32'(my); end
					2: begin c[0] = 32'(mx); c[1] = 32'(my); end
					default: begin c[2] = 32'(mx); c[3] = 32'(my); end
				endcase
			end
			3: begin
				// A degenerate or very short segment.
				if ($urandom_range(0, 1)) begin
					c[2] = c[0] + $urandom_range(0, 3);
					c[3] = c[1];
				end else begin
					c[6] = c[4];
					c[7] = c[5] + $urandom_range(0, 3);
				end
			end
			4: begin
				// Collinear pair along one axis.
				c[1] = c[0];
				c[3] = c[0];
				c[5] = c[0];
				c[7] = c[0];
			end
			5: foreach (c[i]) if ($urandom_range(0, 1)) c[i] = extreme_value();
			default: begin
				// Shared endpoint.
				c[4] = c[2];
				c[5] = c[3];
			end
		endcase
		p.a_start_x = c[0];
		p.a_start_y = c[1];
		p.a_end_x = c[2];
		p.a_end_y = c[3];
		p.b_start_x = c[4];
		p.b_start_y = c[5];
		p.b_end_x = c[6];
		p.b_end_y = c[7];
		return p;
	endfunction

	task automatic run_directed();
		int one;
		one = 65536;
		send(make_pair(-one, 0, one, 0, 0, -one, 0, one));
		send(make_pair(-one, 0, one, 0, 3, 0, 0, one));
		send(make_pair(-one, 0, one, 0, 0, one, 5, 0));
		send(make_pair(0, 0, 0, one, -one, 0, one, 0));
		send(make_pair(0, one, 0, 0, -one, 0, one, 0));
		send(make_pair(7, 7, 7, 7, 7, 7, 7, 7));
		send(make_pair(7, 7, 7, 7, 100, 100, 100, 100));
		send(make_pair(0, 0, 10 * one, 0, 2 * one, 0, 5 * one, 0));
		send(make_pair(0, 0, one, 0, 0, one, one, one));
		send(make_pair(0, 0, 3, 1, 0, 1, 3, 0));
		send(make_pair(32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff,
			32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h80000000));
		send(make_pair(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
			32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff));
		send(make_pair(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
			32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000));
		send(make_pair(-1, -1, -1, -1, 0, 0, 0, 0));
		send(make_pair(32'h80000000, 0, 32'h7fffffff, 0, 0, 32'h80000000, 1, 32'h7fffffff));
		send(make_pair(0, 0, 10, 0, 5, 1, 5, 100));
		send(make_pair(0, 0, 10, 0, 10, 1, 20, 50));
		send(make_pair(0, 0, 10, 10, 0, 10, 10, 0));
	endtask

	initial begin
		logic [15:0] eps_list[6];
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		in_valid = 1'b0;
		in_data = '0;
		long_hold = 1'b0;
		burst_left = 0;
		eps_list = '{16'd1, 16'd0, 16'hffff, 16'd300, 16'd1, 16'd17};
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (eps_list[k]) begin
			if (k > 0) write_epsilon(k == 5 ? 16'($urandom()) : eps_list[k]);
			run_directed();
			if (k == 2) long_hold = 1'b1;
			repeat (300) send(random_pair());
		end
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		if (errors == 0 && pending == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule

@@ files.f @@
hdl/spi_pkg.sv
hdl/segment_pair_intersection_top.sv
hdl/spi_checker.sv
sim/spi_checker.sv
sim/tb.sv
